// ----- hdl/cnmt_pkg.sv -----
// ----------------------------------------------------------------------------
// cnmt_pkg
// Shared types and constants for the CANopen NMT / expedited SDO server.
// ----------------------------------------------------------------------------
package cnmt_pkg;

  // NMT mode encoding held in the state register
  localparam logic [1:0] MODE_INIT    = 2'd0;
  localparam logic [1:0] MODE_PREOP   = 2'd1;
  localparam logic [1:0] MODE_OPER    = 2'd2;
  localparam logic [1:0] MODE_STOPPED = 2'd3;

  // NMT state codes as reported on the bus
  localparam logic [6:0] STATE_INIT    = 7'd0;
  localparam logic [6:0] STATE_STOPPED = 7'd4;
  localparam logic [6:0] STATE_OPER    = 7'd5;
  localparam logic [6:0] STATE_PREOP   = 7'd127;

  // NMT commands
  localparam logic [7:0] NMT_START      = 8'h01;
  localparam logic [7:0] NMT_STOP       = 8'h02;
  localparam logic [7:0] NMT_PREOP      = 8'h80;
  localparam logic [7:0] NMT_RESET_NODE = 8'h81;
  localparam logic [7:0] NMT_RESET_COMM = 8'h82;

  // SDO command specifiers
  localparam logic [7:0] CS_UPLOAD_REQ = 8'h40;
  localparam logic [7:0] CS_UPLOAD_RSP = 8'h4B;
  localparam logic [7:0] CS_DNLOAD_4B  = 8'h23;
  localparam logic [7:0] CS_DNLOAD_2B  = 8'h2B;
  localparam logic [7:0] CS_DNLOAD_RSP = 8'h60;
  localparam logic [7:0] CS_ABORT      = 8'h80;

  // SDO abort codes
  localparam logic [31:0] ABORT_NO_OBJECT = 32'h0602_0000;
  localparam logic [31:0] ABORT_READ_ONLY = 32'h0601_0002;

  // CAN identifier bases
  localparam logic [10:0] COB_NMT    = 11'h000;
  localparam logic [10:0] COB_SDO_RX = 11'h600;
  localparam logic [10:0] COB_SDO_TX = 11'h580;

  // Object reset values
  localparam logic [15:0] SENSOR_RESET   = 16'h1234;
  localparam logic [15:0] SETPOINT_RESET = 16'h0064;

  // Configuration register indexes and reset values
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_NODE_ADDRESS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HB_PERIOD     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HB_INDEX      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SENSOR_INDEX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT_INDEX = 3'd4;

  localparam logic [6:0]  NODE_ADDRESS_RESET   = 7'd1;
  localparam logic [15:0] HB_PERIOD_RESET      = 16'd1000;
  localparam logic [15:0] HB_INDEX_RESET       = 16'h1017;
  localparam logic [15:0] SENSOR_INDEX_RESET   = 16'h6000;
  localparam logic [15:0] SETPOINT_INDEX_RESET = 16'h6001;

  typedef struct packed {
    logic [6:0]  node_address;
    logic [15:0] heartbeat_period;
    logic [15:0] heartbeat_object_index;
    logic [15:0] sensor_object_index;
    logic [15:0] setpoint_object_index;
  } cfg_t;

  // One result item
  typedef struct packed {
    logic        tx_send;
    logic [10:0] tx_identifier;
    logic [7:0]  tx_byte0;
    logic [7:0]  tx_byte1;
    logic [7:0]  tx_byte2;
    logic [7:0]  tx_byte3;
    logic [7:0]  tx_byte4;
    logic [7:0]  tx_byte5;
    logic [7:0]  tx_byte6;
    logic [7:0]  tx_byte7;
    logic [6:0]  node_state;
  } result_t;

  // State updates produced by one frame
  typedef struct packed {
    logic        mode_we;
    logic [1:0]  mode;
    logic        sensor_we;
    logic        setpoint_we;
    logic [15:0] value;
  } update_t;

  function automatic logic [6:0] state_code(input logic [1:0] mode);
    logic [6:0] code;
    case (mode)
      MODE_INIT:  code = STATE_INIT;
      MODE_PREOP: code = STATE_PREOP;
      MODE_OPER:  code = STATE_OPER;
      default:    code = STATE_STOPPED;
    endcase
    return code;
  endfunction

endpackage

// ----- hdl/cnmt_decode.sv -----
// ----------------------------------------------------------------------------
// cnmt_decode
// Frame decode: NMT command handling and expedited SDO reply assembly.
// ----------------------------------------------------------------------------
module cnmt_decode (
  input  cnmt_pkg::cfg_t    cfg,
  input  logic [1:0]        mode,
  input  logic [15:0]       sensor,
  input  logic [15:0]       setpoint,
  input  logic [10:0]       rx_identifier,
  input  logic [3:0]        rx_length,
  input  logic [7:0]        rx_byte0,
  input  logic [7:0]        rx_byte1,
  input  logic [7:0]        rx_byte2,
  input  logic [7:0]        rx_byte3,
  input  logic [7:0]        rx_byte4,
  input  logic [7:0]        rx_byte5,
  output cnmt_pkg::result_t result,
  output cnmt_pkg::update_t update
);

  logic [10:0] sdo_rx_id;
  logic [15:0] idx;
  logic        sub_zero;
  logic        hit_hb;
  logic        hit_sensor;
  logic        hit_setpoint;
  logic        is_nmt;
  logic        is_req;
  logic        up;
  logic        down;
  logic [1:0]  mode_after;
  logic [31:0] abort_word;
  logic        do_abort;

  assign sdo_rx_id    = cnmt_pkg::COB_SDO_RX + {4'd0, cfg.node_address};
  assign idx          = {rx_byte2, rx_byte1};
  assign sub_zero     = (rx_byte3 == 8'd0);
  assign hit_hb       = (idx == cfg.heartbeat_object_index);
  assign hit_sensor   = (idx == cfg.sensor_object_index);
  assign hit_setpoint = (idx == cfg.setpoint_object_index);

  // Frame classification
  assign is_nmt = (rx_identifier == cnmt_pkg::COB_NMT) && (rx_length >= 4'd2) &&
                  ((rx_byte1 == 8'd0) || (rx_byte1 == {1'b0, cfg.node_address}));
  assign is_req = (rx_identifier == sdo_rx_id) && (rx_length >= 4'd4);
  assign up     = (rx_byte0 == cnmt_pkg::CS_UPLOAD_REQ);

  always_comb begin
    down = rx_byte0 inside {cnmt_pkg::CS_DNLOAD_4B, cnmt_pkg::CS_DNLOAD_2B};
  end

  // NMT state transition
  always_comb begin
    mode_after = mode;
    if (is_nmt) begin
      case (rx_byte0)
        cnmt_pkg::NMT_START: begin
          mode_after = cnmt_pkg::MODE_OPER;
        end
        cnmt_pkg::NMT_STOP: begin
          mode_after = cnmt_pkg::MODE_STOPPED;
        end
        cnmt_pkg::NMT_PREOP, cnmt_pkg::NMT_RESET_NODE, cnmt_pkg::NMT_RESET_COMM: begin
          mode_after = cnmt_pkg::MODE_PREOP;
        end
        default: begin
          mode_after = mode;
        end
      endcase
    end
  end

  // SDO reply and object writes
  always_comb begin
    result               = '0;
    update               = '0;
    abort_word           = cnmt_pkg::ABORT_NO_OBJECT;
    do_abort             = 1'b0;
    update.mode_we       = is_nmt;
    update.mode          = mode_after;
    update.value         = {rx_byte5, rx_byte4};
    result.tx_identifier = cnmt_pkg::COB_SDO_TX + {4'd0, cfg.node_address};
    result.node_state    = cnmt_pkg::state_code(mode_after);

    if (is_req && (up || down)) begin
      result.tx_send  = 1'b1;
      result.tx_byte1 = rx_byte1;
      result.tx_byte2 = rx_byte2;
      result.tx_byte3 = rx_byte3;
      if (up) begin
        result.tx_byte0 = cnmt_pkg::CS_UPLOAD_RSP;
        if (hit_hb && sub_zero) begin
          {result.tx_byte5, result.tx_byte4} = cfg.heartbeat_period;
        end else if (hit_sensor && sub_zero) begin
          {result.tx_byte5, result.tx_byte4} = sensor;
        end else if (hit_setpoint && sub_zero) begin
          {result.tx_byte5, result.tx_byte4} = setpoint;
        end else begin
          do_abort = 1'b1;
        end
      end else begin
        result.tx_byte0 = cnmt_pkg::CS_DNLOAD_RSP;
        if (hit_hb) begin
          do_abort   = 1'b1;
          abort_word = cnmt_pkg::ABORT_READ_ONLY;
        end else if (hit_sensor && sub_zero) begin
          update.sensor_we = 1'b1;
        end else if (hit_setpoint && sub_zero) begin
          update.setpoint_we = 1'b1;
        end else begin
          do_abort = 1'b1;
        end
      end
      if (do_abort) begin
        result.tx_byte0 = cnmt_pkg::CS_ABORT;
        {result.tx_byte7, result.tx_byte6, result.tx_byte5, result.tx_byte4} = abort_word;
      end
    end
  end

endmodule

// ----- hdl/cnmt_outbuf.sv -----
// ----------------------------------------------------------------------------
// cnmt_outbuf
// Two-entry result buffer: output register plus skid register, so the
// input side ready comes straight from a flop.
// ----------------------------------------------------------------------------
module cnmt_outbuf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cnmt_pkg::result_t push_data,
  output logic              push_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output cnmt_pkg::result_t out_data
);

  logic              out_valid_r;
  logic              skid_valid_r;
  cnmt_pkg::result_t out_data_r;
  cnmt_pkg::result_t skid_data_r;
  logic              out_free;

  assign push_ready = !skid_valid_r;
  assign out_valid  = out_valid_r;
  assign out_data   = out_data_r;
  assign out_free   = !out_valid_r || out_ready;

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r  <= skid_valid_r || push;
      skid_valid_r <= 1'b0;
    end else if (push) begin
      skid_valid_r <= 1'b1;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_data_r <= skid_valid_r ? skid_data_r : push_data;
    end else if (push) begin
      skid_data_r <= push_data;
    end
  end

  // Checks
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r) else $error("skid entry without output entry");
  a_held_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(out_data_r))
    else $error("stalled result changed");
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !out_ready |=> skid_valid_r && $stable(skid_data_r))
    else $error("skid entry overwritten");

endmodule

// ----- hdl/canopen_nmt_sdo_slave_top.sv -----
// ----------------------------------------------------------------------------
// canopen_nmt_sdo_slave_top
// CANopen NMT slave with an expedited SDO server for three 16-bit objects.
// ----------------------------------------------------------------------------
// The block takes one received frame per clock while in_ready is high and
// returns exactly one result per frame, in order, registered in the output
// register or, while the output stalls, in the skid register of a two-entry
// buffer. Decode is a single pass of compare-and-select logic between the
// input ports and the result register; the NMT mode and the two writable
// objects update on the same edge, so the next frame sees them. in_ready drops
// only when both entries are full, and comes from a flop. Configuration writes
// take effect on the next edge and must be made while no result is outstanding.
// ----------------------------------------------------------------------------
module canopen_nmt_sdo_slave_top (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // received frame
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [10:0] in_rx_identifier,
  input  logic [3:0]  in_rx_length,
  input  logic [7:0]  in_rx_byte0,
  input  logic [7:0]  in_rx_byte1,
  input  logic [7:0]  in_rx_byte2,
  input  logic [7:0]  in_rx_byte3,
  input  logic [7:0]  in_rx_byte4,
  input  logic [7:0]  in_rx_byte5,
  input  logic [7:0]  in_rx_byte6,
  input  logic [7:0]  in_rx_byte7,
  // result
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_tx_send,
  output logic [10:0] out_tx_identifier,
  output logic [7:0]  out_tx_byte0,
  output logic [7:0]  out_tx_byte1,
  output logic [7:0]  out_tx_byte2,
  output logic [7:0]  out_tx_byte3,
  output logic [7:0]  out_tx_byte4,
  output logic [7:0]  out_tx_byte5,
  output logic [7:0]  out_tx_byte6,
  output logic [7:0]  out_tx_byte7,
  output logic [6:0]  out_node_state
);

  cnmt_pkg::cfg_t    cfg_r;
  logic [1:0]        mode_r;
  logic [15:0]       sensor_r;
  logic [15:0]       setpoint_r;
  cnmt_pkg::result_t result;
  cnmt_pkg::update_t update;
  cnmt_pkg::result_t out_data;
  logic              push;
  logic              unused_bytes;

  // bytes 6 and 7 carry nothing this server uses
  assign unused_bytes = ^{in_rx_byte6, in_rx_byte7};

  assign push = in_valid && in_ready && (unused_bytes || !unused_bytes);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.node_address           <= cnmt_pkg::NODE_ADDRESS_RESET;
      cfg_r.heartbeat_period       <= cnmt_pkg::HB_PERIOD_RESET;
      cfg_r.heartbeat_object_index <= cnmt_pkg::HB_INDEX_RESET;
      cfg_r.sensor_object_index    <= cnmt_pkg::SENSOR_INDEX_RESET;
      cfg_r.setpoint_object_index  <= cnmt_pkg::SETPOINT_INDEX_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        cnmt_pkg::REG_NODE_ADDRESS:   cfg_r.node_address           <= cfg_data[6:0];
        cnmt_pkg::REG_HB_PERIOD:      cfg_r.heartbeat_period       <= cfg_data;
        cnmt_pkg::REG_HB_INDEX:       cfg_r.heartbeat_object_index <= cfg_data;
        cnmt_pkg::REG_SENSOR_INDEX:   cfg_r.sensor_object_index    <= cfg_data;
        cnmt_pkg::REG_SETPOINT_INDEX: cfg_r.setpoint_object_index  <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Frame decode
  cnmt_decode u_decode (
    .cfg           (cfg_r),
    .mode          (mode_r),
    .sensor        (sensor_r),
    .setpoint      (setpoint_r),
    .rx_identifier (in_rx_identifier),
    .rx_length     (in_rx_length),
    .rx_byte0      (in_rx_byte0),
    .rx_byte1      (in_rx_byte1),
    .rx_byte2      (in_rx_byte2),
    .rx_byte3      (in_rx_byte3),
    .rx_byte4      (in_rx_byte4),
    .rx_byte5      (in_rx_byte5),
    .result        (result),
    .update        (update)
  );

  // NMT mode and dictionary objects
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= cnmt_pkg::MODE_OPER;
      sensor_r   <= cnmt_pkg::SENSOR_RESET;
      setpoint_r <= cnmt_pkg::SETPOINT_RESET;
    end else if (push) begin
      if (update.mode_we) begin
        mode_r <= update.mode;
      end
      if (update.sensor_we) begin
        sensor_r <= update.value;
      end
      if (update.setpoint_we) begin
        setpoint_r <= update.value;
      end
    end
  end

  // Result buffer
  cnmt_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_data  (result),
    .push_ready (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  assign out_tx_send       = out_data.tx_send;
  assign out_tx_identifier = out_data.tx_identifier;
  assign out_tx_byte0      = out_data.tx_byte0;
  assign out_tx_byte1      = out_data.tx_byte1;
  assign out_tx_byte2      = out_data.tx_byte2;
  assign out_tx_byte3      = out_data.tx_byte3;
  assign out_tx_byte4      = out_data.tx_byte4;
  assign out_tx_byte5      = out_data.tx_byte5;
  assign out_tx_byte6      = out_data.tx_byte6;
  assign out_tx_byte7      = out_data.tx_byte7;
  assign out_node_state    = out_data.node_state;

  // Checks
  a_never_init: assert property (@(posedge clk) disable iff (!rst_n)
    mode_r != cnmt_pkg::MODE_INIT) else $error("NMT mode entered init");
  a_quiet_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_tx_send |->
      {out_tx_byte0, out_tx_byte1, out_tx_byte2, out_tx_byte3,
       out_tx_byte4, out_tx_byte5, out_tx_byte6, out_tx_byte7} == 64'd0)
    else $error("payload bytes set without a reply");
  a_reply_command: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_tx_send |->
      (out_tx_byte0 == cnmt_pkg::CS_UPLOAD_RSP) ||
      (out_tx_byte0 == cnmt_pkg::CS_DNLOAD_RSP) ||
      (out_tx_byte0 == cnmt_pkg::CS_ABORT))
    else $error("reply with unknown command specifier");
  a_single_write: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !(update.sensor_we && update.setpoint_we) &&
             !((update.sensor_we || update.setpoint_we) && update.mode_we))
    else $error("one frame wrote more than one state element");

endmodule

// ----- tb/canopen_nmt_sdo_slave_checker.sv -----
// ----------------------------------------------------------------------------
// canopen_nmt_sdo_slave_checker
// Watches the frame, result and register ports of the NMT / SDO server,
// keeps its own copy of the NMT mode, the two writable objects and the
// register set, predicts one reply per accepted frame and compares every
// accepted result with the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module canopen_nmt_sdo_slave_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [10:0] in_rx_identifier,
  input  logic [3:0]  in_rx_length,
  input  logic [7:0]  in_rx_byte0,
  input  logic [7:0]  in_rx_byte1,
  input  logic [7:0]  in_rx_byte2,
  input  logic [7:0]  in_rx_byte3,
  input  logic [7:0]  in_rx_byte4,
  input  logic [7:0]  in_rx_byte5,
  input  logic [7:0]  in_rx_byte6,
  input  logic [7:0]  in_rx_byte7,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic        out_tx_send,
  input  logic [10:0] out_tx_identifier,
  input  logic [7:0]  out_tx_byte0,
  input  logic [7:0]  out_tx_byte1,
  input  logic [7:0]  out_tx_byte2,
  input  logic [7:0]  out_tx_byte3,
  input  logic [7:0]  out_tx_byte4,
  input  logic [7:0]  out_tx_byte5,
  input  logic [7:0]  out_tx_byte6,
  input  logic [7:0]  out_tx_byte7,
  input  logic [6:0]  out_node_state,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  // shadow of the block's registers and state
  cnmt_pkg::cfg_t regs;
  logic [1:0]     mode_q;
  logic [15:0]    sensor_val;
  logic [15:0]    setpoint_val;

  cnmt_pkg::result_t expected_replies [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  // Serve one received frame: NMT moves the mode, SDO requests get a reply.
  function automatic cnmt_pkg::result_t serve_frame(input logic [10:0] id,
                                                    input logic [3:0] len,
                                                    input logic [7:0][7:0] d);
    cnmt_pkg::result_t r;
    logic [15:0]       obj_idx;
    logic [15:0]       value;
    logic              up;
    logic              down;
    r       = '0;
    obj_idx = {d[2], d[1]};
    value   = {d[5], d[4]};
    up      = (d[0] == cnmt_pkg::CS_UPLOAD_REQ);
    down    = (d[0] == cnmt_pkg::CS_DNLOAD_4B) || (d[0] == cnmt_pkg::CS_DNLOAD_2B);

    if (id == cnmt_pkg::COB_NMT) begin
      if (len >= 4'd2 && (d[1] == 8'd0 || d[1] == {1'b0, regs.node_address})) begin
        case (d[0])
          cnmt_pkg::NMT_START:      mode_q = cnmt_pkg::MODE_OPER;
          cnmt_pkg::NMT_STOP:       mode_q = cnmt_pkg::MODE_STOPPED;
          cnmt_pkg::NMT_PREOP,
          cnmt_pkg::NMT_RESET_NODE,
          cnmt_pkg::NMT_RESET_COMM: mode_q = cnmt_pkg::MODE_PREOP;
          default:                  ;  // unknown command keeps the mode
        endcase
      end
    end else if (id == cnmt_pkg::COB_SDO_RX + {4'd0, regs.node_address} && len >= 4'd4
                 && (up || down)) begin
      r.tx_send  = 1'b1;
      r.tx_byte1 = d[1];
      r.tx_byte2 = d[2];
      r.tx_byte3 = d[3];
      if (up) begin
        // heartbeat, sensor, setpoint in that order; first match wins
        if (obj_idx == regs.heartbeat_object_index && d[3] == 8'd0) begin
          r.tx_byte0 = cnmt_pkg::CS_UPLOAD_RSP;
          {r.tx_byte5, r.tx_byte4} = regs.heartbeat_period;
        end else if (obj_idx == regs.sensor_object_index && d[3] == 8'd0) begin
          r.tx_byte0 = cnmt_pkg::CS_UPLOAD_RSP;
          {r.tx_byte5, r.tx_byte4} = sensor_val;
        end else if (obj_idx == regs.setpoint_object_index && d[3] == 8'd0) begin
          r.tx_byte0 = cnmt_pkg::CS_UPLOAD_RSP;
          {r.tx_byte5, r.tx_byte4} = setpoint_val;
        end else begin
          r.tx_byte0 = cnmt_pkg::CS_ABORT;
          {r.tx_byte7, r.tx_byte6, r.tx_byte5, r.tx_byte4} = cnmt_pkg::ABORT_NO_OBJECT;
        end
      end else begin
        // heartbeat is read-only at any subindex
        if (obj_idx == regs.heartbeat_object_index) begin
          r.tx_byte0 = cnmt_pkg::CS_ABORT;
          {r.tx_byte7, r.tx_byte6, r.tx_byte5, r.tx_byte4} = cnmt_pkg::ABORT_READ_ONLY;
        end else if (obj_idx == regs.sensor_object_index && d[3] == 8'd0) begin
          sensor_val = value;
          r.tx_byte0 = cnmt_pkg::CS_DNLOAD_RSP;
        end else if (obj_idx == regs.setpoint_object_index && d[3] == 8'd0) begin
          setpoint_val = value;
          r.tx_byte0 = cnmt_pkg::CS_DNLOAD_RSP;
        end else begin
          r.tx_byte0 = cnmt_pkg::CS_ABORT;
          {r.tx_byte7, r.tx_byte6, r.tx_byte5, r.tx_byte4} = cnmt_pkg::ABORT_NO_OBJECT;
        end
      end
    end

    r.tx_identifier = cnmt_pkg::COB_SDO_TX + {4'd0, regs.node_address};
    case (mode_q)
      cnmt_pkg::MODE_INIT:  r.node_state = cnmt_pkg::STATE_INIT;
      cnmt_pkg::MODE_PREOP: r.node_state = cnmt_pkg::STATE_PREOP;
      cnmt_pkg::MODE_OPER:  r.node_state = cnmt_pkg::STATE_OPER;
      default:              r.node_state = cnmt_pkg::STATE_STOPPED;
    endcase
    return r;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Compare results, predict new frames, follow register writes.
  always @(posedge clk) begin
    cnmt_pkg::result_t want;
    if (!rst_n) begin
      regs         = '{cnmt_pkg::NODE_ADDRESS_RESET, cnmt_pkg::HB_PERIOD_RESET,
                       cnmt_pkg::HB_INDEX_RESET, cnmt_pkg::SENSOR_INDEX_RESET,
                       cnmt_pkg::SETPOINT_INDEX_RESET};
      mode_q       = cnmt_pkg::MODE_OPER;
      sensor_val   = cnmt_pkg::SENSOR_RESET;
      setpoint_val = cnmt_pkg::SETPOINT_RESET;
      expected_replies.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          $error("result transfer with no reply expected");
          mismatches++;
        end else begin
          want = expected_replies.pop_front();
          check_field("tx_send",       16'(want.tx_send),       16'(out_tx_send));
          check_field("tx_identifier", 16'(want.tx_identifier), 16'(out_tx_identifier));
          check_field("tx_byte0",      16'(want.tx_byte0),      16'(out_tx_byte0));
          check_field("tx_byte1",      16'(want.tx_byte1),      16'(out_tx_byte1));
          check_field("tx_byte2",      16'(want.tx_byte2),      16'(out_tx_byte2));
          check_field("tx_byte3",      16'(want.tx_byte3),      16'(out_tx_byte3));
          check_field("tx_byte4",      16'(want.tx_byte4),      16'(out_tx_byte4));
          check_field("tx_byte5",      16'(want.tx_byte5),      16'(out_tx_byte5));
          check_field("tx_byte6",      16'(want.tx_byte6),      16'(out_tx_byte6));
          check_field("tx_byte7",      16'(want.tx_byte7),      16'(out_tx_byte7));
          check_field("node_state",    16'(want.node_state),    16'(out_node_state));
        end
      end
      if (in_valid && in_ready) begin
        expected_replies.push_back(serve_frame(in_rx_identifier, in_rx_length,
          {in_rx_byte7, in_rx_byte6, in_rx_byte5, in_rx_byte4,
           in_rx_byte3, in_rx_byte2, in_rx_byte1, in_rx_byte0}));
      end
      // register write lands after this edge's frame has been decoded
      if (cfg_we) begin
        case (cfg_index)
          cnmt_pkg::REG_NODE_ADDRESS:   regs.node_address           = cfg_data[6:0];
          cnmt_pkg::REG_HB_PERIOD:      regs.heartbeat_period       = cfg_data;
          cnmt_pkg::REG_HB_INDEX:       regs.heartbeat_object_index = cfg_data;
          cnmt_pkg::REG_SENSOR_INDEX:   regs.sensor_object_index    = cfg_data;
          cnmt_pkg::REG_SETPOINT_INDEX: regs.setpoint_object_index  = cfg_data;
          default:                      ;
        endcase
      end
    end
    outstanding = expected_replies.size();
  end

endmodule

// ----- tb/tb_canopen_nmt_sdo_slave_top.sv -----
// ----------------------------------------------------------------------------
// tb_canopen_nmt_sdo_slave_top
// Frame stimulus for the CANopen NMT / SDO server: a directed pass over
// NMT commands, uploads, downloads, aborts and ignored frames, then random
// frame traffic under several register settings, with random gaps on the
// frame side and random stalls on the result side. Checking is done by the
// checker module instantiated beside the block.
// ----------------------------------------------------------------------------
module tb_canopen_nmt_sdo_slave_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT   = 2000;
  localparam int PHASES           = 8;
  localparam int FRAMES_PER_PHASE = 240;

  typedef struct packed {
    logic [10:0]     id;
    logic [3:0]      len;
    logic [7:0][7:0] data;
  } frame_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [10:0] in_rx_identifier;
  logic [3:0]  in_rx_length;
  logic [7:0]  in_rx_byte0, in_rx_byte1, in_rx_byte2, in_rx_byte3;
  logic [7:0]  in_rx_byte4, in_rx_byte5, in_rx_byte6, in_rx_byte7;
  logic        out_valid;
  logic        out_ready;
  logic        out_tx_send;
  logic [10:0] out_tx_identifier;
  logic [7:0]  out_tx_byte0, out_tx_byte1, out_tx_byte2, out_tx_byte3;
  logic [7:0]  out_tx_byte4, out_tx_byte5, out_tx_byte6, out_tx_byte7;
  logic [6:0]  out_node_state;
  int          mismatches;
  int          outstanding;

  cnmt_pkg::cfg_t cur;  // register values last written
  bit   in_calm;        // no frame gaps in this stretch
  bit   out_calm;       // no result stalls in this stretch
  int   stall_left;
  int   stretch_cycles;
  int   idle_cycles;

  canopen_nmt_sdo_slave_top DUT (.*);
  canopen_nmt_sdo_slave_checker u_checker (.*);

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // mostly short gaps, a few long ones
  function automatic int pick_gap(input bit calm);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // result-side stalls and calm stretches
  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_left > 0) begin
        out_ready = 1'b0;
        stall_left--;
      end else begin
        out_ready = 1'b1;
        stall_left = pick_gap(out_calm);
      end
      stretch_cycles++;
      if (stretch_cycles % 150 == 0) begin
        in_calm  = ($urandom_range(0, 3) == 0);
        out_calm = ($urandom_range(0, 3) == 0);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic frame_t mk_frame(input logic [10:0] id, input logic [3:0] len,
                                      input logic [7:0] b0, input logic [7:0] b1,
                                      input logic [7:0] b2, input logic [7:0] b3,
                                      input logic [7:0] b4, input logic [7:0] b5);
    frame_t f;
    f.id   = id;
    f.len  = len;
    f.data = {16'h0000, b5, b4, b3, b2, b1, b0};
    return f;
  endfunction

  function automatic frame_t sdo_req(input logic [7:0] cs, input logic [15:0] obj_idx,
                                     input logic [7:0] sub, input logic [15:0] value,
                                     input logic [3:0] len);
    return mk_frame(cnmt_pkg::COB_SDO_RX + {4'd0, cur.node_address}, len, cs,
                    obj_idx[7:0], obj_idx[15:8], sub, value[7:0], value[15:8]);
  endfunction

  function automatic frame_t nmt_cmd(input logic [7:0] cmd, input logic [7:0] target,
                                     input logic [3:0] len);
    return mk_frame(cnmt_pkg::COB_NMT, len, cmd, target, 8'd0, 8'd0, 8'd0, 8'd0);
  endfunction

  // random frame: half are requests to this node, mostly with a known index
  function automatic frame_t rand_frame();
    frame_t      f;
    int unsigned kind;
    int unsigned pick;
    logic [15:0] obj_idx;
    f.data = {$urandom, $urandom};
    f.id   = 11'($urandom_range(0, 2047));
    f.len  = 4'($urandom_range(0, 15));
    kind   = $urandom_range(0, 99);
    if (kind < 50) begin
      pick = $urandom_range(0, 99);
      f.id = cnmt_pkg::COB_SDO_RX + {4'd0, cur.node_address};
      if (pick < 40)      f.data[0] = cnmt_pkg::CS_UPLOAD_REQ;
      else if (pick < 60) f.data[0] = cnmt_pkg::CS_DNLOAD_4B;
      else if (pick < 80) f.data[0] = cnmt_pkg::CS_DNLOAD_2B;
      case ($urandom_range(0, 3))
        0:       obj_idx = cur.heartbeat_object_index;
        1:       obj_idx = cur.sensor_object_index;
        2:       obj_idx = cur.setpoint_object_index;
        default: obj_idx = 16'($urandom_range(0, 65535));
      endcase
      {f.data[2], f.data[1]} = obj_idx;
      if ($urandom_range(0, 4) != 0) f.data[3] = 8'd0;
      pick  = $urandom_range(0, 99);
      f.len = (pick < 85) ? 4'($urandom_range(4, 8)) :
              (pick < 93) ? 4'($urandom_range(9, 15)) : 4'($urandom_range(0, 3));
    end else if (kind < 78) begin
      f.id = cnmt_pkg::COB_NMT;
      case ($urandom_range(0, 5))
        0: f.data[0] = cnmt_pkg::NMT_START;
        1: f.data[0] = cnmt_pkg::NMT_STOP;
        2: f.data[0] = cnmt_pkg::NMT_PREOP;
        3: f.data[0] = cnmt_pkg::NMT_RESET_NODE;
        4: f.data[0] = cnmt_pkg::NMT_RESET_COMM;
        default: ;
      endcase
      pick = $urandom_range(0, 9);
      if (pick < 4)      f.data[1] = 8'd0;
      else if (pick < 8) f.data[1] = {1'b0, cur.node_address};
      f.len = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 1))
                                          : 4'($urandom_range(2, 15));
    end else if (kind < 88) begin
      // request to some other node
      f.id = cnmt_pkg::COB_SDO_RX +
             {4'd0, cur.node_address + 7'($urandom_range(1, 127))};
    end
    return f;
  endfunction

  // one frame transfer with a random gap in front
  task automatic send_frame(input frame_t f);
    int gap;
    gap = pick_gap(in_calm);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_rx_identifier = f.id;
    in_rx_length     = f.len;
    {in_rx_byte7, in_rx_byte6, in_rx_byte5, in_rx_byte4,
     in_rx_byte3, in_rx_byte2, in_rx_byte1, in_rx_byte0} = f.data;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  // stop sending and let every reply come back
  task automatic drain();
    in_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic write_all(input cnmt_pkg::cfg_t c);
    cur = c;
    write_reg(cnmt_pkg::REG_NODE_ADDRESS,   {9'd0, c.node_address});
    write_reg(cnmt_pkg::REG_HB_PERIOD,      c.heartbeat_period);
    write_reg(cnmt_pkg::REG_HB_INDEX,       c.heartbeat_object_index);
    write_reg(cnmt_pkg::REG_SENSOR_INDEX,   c.sensor_object_index);
    write_reg(cnmt_pkg::REG_SETPOINT_INDEX, c.setpoint_object_index);
  endtask

  // stimulus
  initial begin
    cnmt_pkg::cfg_t c;
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = cnmt_pkg::REG_NODE_ADDRESS;
    cfg_data         = '0;
    in_valid         = 1'b0;
    in_rx_identifier = '0;
    in_rx_length     = '0;
    {in_rx_byte7, in_rx_byte6, in_rx_byte5, in_rx_byte4,
     in_rx_byte3, in_rx_byte2, in_rx_byte1, in_rx_byte0} = '0;
    out_ready        = 1'b0;
    stall_left       = 0;
    stretch_cycles   = 0;
    idle_cycles      = 0;
    in_calm          = 1'b0;
    out_calm         = 1'b0;
    cur = '{cnmt_pkg::NODE_ADDRESS_RESET, cnmt_pkg::HB_PERIOD_RESET,
            cnmt_pkg::HB_INDEX_RESET, cnmt_pkg::SENSOR_INDEX_RESET,
            cnmt_pkg::SETPOINT_INDEX_RESET};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: uploads, downloads, aborts, NMT commands, ignored frames
    send_frame(sdo_req(cnmt_pkg::CS_UPLOAD_REQ, cur.heartbeat_object_index, 8'd0,
                       16'd0, 4'd8));
    send_frame(sdo_req(cnmt_pkg::CS_UPLOAD_REQ, cur.sensor_object_index, 8'd0,
                       16'd0, 4'd8));
    send_frame(sdo_req(cnmt_pkg::CS_UPLOAD_REQ, cur.setpoint_object_index, 8'd0,
                       16'd0, 4'd4));
    send_frame(sdo_req(cnmt_pkg::CS_UPLOAD_REQ, cur.sensor_object_index, 8'd1,
                       16'd0, 4'd8));
    send_frame(sdo_req(cnmt_pkg::CS_UPLOAD_REQ, 16'h2000, 8'd0, 16'd0, 4'd8));
    send_frame(sdo_req(cnmt_pkg::CS_DNLOAD_4B, cur.sensor_object_index, 8'd0,
                       16'hBEEF, 4'd8));
    send_frame(sdo_req(cnmt_pkg::CS_UPLOAD_REQ, cur.sensor_object_index, 8'd0,
                       16'd0, 4'd8));
    send_frame(sdo_req(cnmt_pkg::CS_DNLOAD_2B, cur.setpoint_object_index, 8'd0,
                       16'hFFFF, 4'd6));
    send_frame(sdo_req(cnmt_pkg::CS_UPLOAD_REQ, cur.setpoint_object_index, 8'd0,
                       16'd0, 4'd8));
    send_frame(sdo_req(cnmt_pkg::CS_DNLOAD_4B, cur.heartbeat_object_index, 8'd7,
                       16'h5555, 4'd8));
    send_frame(sdo_req(cnmt_pkg::CS_DNLOAD_2B, cur.setpoint_object_index, 8'd1,
                       16'h0001, 4'd8));
    send_frame(sdo_req(cnmt_pkg::CS_DNLOAD_4B, 16'hFFFF, 8'd0, 16'h00FF, 4'd8));
    send_frame(sdo_req(8'h41, cur.sensor_object_index, 8'd0, 16'd0, 4'd8));
    send_frame(sdo_req(cnmt_pkg::CS_UPLOAD_REQ, cur.sensor_object_index, 8'd0,
                       16'd0, 4'd3));
    send_frame(sdo_req(cnmt_pkg::CS_UPLOAD_REQ, cur.sensor_object_index, 8'd0,
                       16'd0, 4'd15));
    send_frame(nmt_cmd(cnmt_pkg::NMT_STOP, 8'd0, 4'd2));
    send_frame(sdo_req(cnmt_pkg::CS_UPLOAD_REQ, cur.heartbeat_object_index, 8'd0,
                       16'd0, 4'd8));
    send_frame(nmt_cmd(cnmt_pkg::NMT_PREOP, {1'b0, cur.node_address}, 4'd2));
    send_frame(nmt_cmd(cnmt_pkg::NMT_RESET_NODE, 8'd0, 4'd8));
    send_frame(nmt_cmd(cnmt_pkg::NMT_START, 8'd0, 4'd2));
    send_frame(nmt_cmd(cnmt_pkg::NMT_RESET_COMM, {1'b0, cur.node_address}, 4'd15));
    send_frame(nmt_cmd(8'h55, {1'b0, cur.node_address}, 4'd2));
    send_frame(nmt_cmd(cnmt_pkg::NMT_STOP, 8'd0, 4'd1));
    send_frame(nmt_cmd(cnmt_pkg::NMT_STOP, 8'd9, 4'd2));
    send_frame('{11'h7FF, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF});
    send_frame(nmt_cmd(cnmt_pkg::NMT_START, 8'd0, 4'd2));

    // random traffic under several register settings
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        drain();
        case (phase)
          1: c = '{7'd127, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001};
          2: c = '{7'd1, 16'h0000, 16'h0000, 16'hFFFF, 16'h8000};
          3: c = '{7'($urandom_range(1, 127)), 16'($urandom), 16'h2000, 16'h2000, 16'h2000};
          4: c = '{7'($urandom_range(1, 127)), 16'($urandom), 16'h1017, 16'h6000, 16'h6000};
          default:
            c = '{7'($urandom_range(1, 127)), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom)};
        endcase
        write_all(c);
      end
      repeat (FRAMES_PER_PHASE) send_frame(rand_frame());
    end

    drain();
    repeat (5) @(negedge clk);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
